/* rtl/i2cw_pkg.sv */
// Shared types and constants for the I2C master write engine.
// No dependencies; used by every other file of the block but i2cw_chan_if.
package i2cw_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_WRITE = 2'd3
  } action_e;

  localparam int unsigned StepW = 5;
  localparam int unsigned TickW = 8;
  localparam int unsigned ByteW = 8;

  localparam logic [StepW-1:0] StartPhases    = StepW'(3);
  localparam logic [StepW-1:0] StopPhases     = StepW'(4);
  localparam logic [StepW-1:0] WritePhases    = StepW'(27);
  localparam logic [StepW-1:0] DataPhasesEnd  = StepW'(24);
  localparam logic [StepW-1:0] SdaReleasePh   = StepW'(25);
  localparam logic [StepW-1:0] AckSamplePhase = StepW'(26);
  localparam logic [TickW-1:0] PhaseTicksRst  = TickW'(20);

  typedef struct packed {
    action_e          action;
    logic [ByteW-1:0] byte_value;
    logic             sda_in;
  } in_item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic done_res;
    logic acked;
    logic rejected;
  } out_item_t;

  typedef logic [TickW-1:0] cfg_word_t;

  function automatic logic [StepW-1:0] phase_total(action_e kind);
    logic [StepW-1:0] total;
    case (kind)
      ACT_START: total = StartPhases;
      ACT_STOP:  total = StopPhases;
      default:   total = WritePhases;
    endcase
    return total;
  endfunction

endpackage

/* rtl/i2cw_chan_if.sv */
// Valid/ready channel carrying one word of a given payload type.
// Payload types come from i2cw_pkg at the point of instantiation.
interface i2cw_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/i2cw_in_reg.sv */
// Input register stage: captures one input word ahead of the sequencer.
// Depends on i2cw_pkg and i2cw_chan_if.
module i2cw_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2cw_chan_if.sink         in_i,
  input  logic              take_i,
  output logic              valid_o,
  output i2cw_pkg::in_item_t item_o
);

  logic               valid_q;
  i2cw_pkg::in_item_t item_q;

  // a word may enter when the stage is empty or drains this cycle
  assign in_i.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= in_i.data;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/i2cw_seq.sv */
// Bus sequencer: phase state, hold counter, pin drives and the phase_ticks register.
// Depends on i2cw_pkg and i2cw_chan_if (configuration channel).
module i2cw_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  i2cw_chan_if.sink           cfg_i,
  input  logic                fire_i,
  input  i2cw_pkg::in_item_t  item_i,
  output i2cw_pkg::out_item_t result_o
);

  localparam int unsigned StepW = i2cw_pkg::StepW;
  localparam int unsigned TickW = i2cw_pkg::TickW;
  localparam int unsigned ByteW = i2cw_pkg::ByteW;

  i2cw_pkg::cfg_word_t  phase_ticks_q;
  logic [StepW-1:0]     step_q, step_d;
  i2cw_pkg::action_e    kind_q, kind_d;
  logic [TickW-1:0]     wait_q, wait_d;
  logic [ByteW-1:0]     shift_q, shift_d;
  logic [1:0]           sub_q, sub_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  logic                 ack_q, ack_d;

  logic [TickW-1:0]     hold;
  logic                 apply_en;
  logic                 done;
  logic                 rejected;
  logic                 acked;

  assign cfg_i.ready = 1'b1;
  assign hold = (phase_ticks_q == '0) ? TickW'(1) : phase_ticks_q;

  always_comb begin
    step_d   = step_q;
    kind_d   = kind_q;
    wait_d   = wait_q;
    shift_d  = shift_q;
    sub_d    = sub_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    ack_d    = ack_q;
    apply_en = 1'b0;
    done     = 1'b0;
    rejected = 1'b0;
    acked    = 1'b0;

    if (step_q != '0) begin
      rejected = (item_i.action != i2cw_pkg::ACT_TICK);
      if (wait_q > TickW'(1)) begin
        wait_d = wait_q - TickW'(1);
      end else begin
        wait_d = '0;
        if (kind_q == i2cw_pkg::ACT_WRITE && step_q == i2cw_pkg::AckSamplePhase) begin
          ack_d = !item_i.sda_in;
        end
        if (step_q >= i2cw_pkg::phase_total(kind_q)) begin
          done   = 1'b1;
          acked  = (kind_q == i2cw_pkg::ACT_WRITE) && ack_d;
          step_d = '0;
        end else begin
          step_d   = step_q + StepW'(1);
          sub_d    = (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
          apply_en = 1'b1;
          wait_d   = hold;
        end
      end
    end else if (item_i.action != i2cw_pkg::ACT_TICK) begin
      kind_d = item_i.action;
      ack_d  = 1'b0;
      if (item_i.action == i2cw_pkg::ACT_WRITE) begin
        shift_d = item_i.byte_value;
      end
      step_d   = StepW'(1);
      sub_d    = 2'd0;
      apply_en = 1'b1;
      wait_d   = hold;
    end

    // pin change for the phase just entered
    if (apply_en) begin
      case (kind_d)
        i2cw_pkg::ACT_START: begin
          if (step_d == StepW'(1)) begin
            sda_d = 1'b1;
            scl_d = 1'b1;
          end else if (step_d == StepW'(2)) begin
            sda_d = 1'b0;
          end else begin
            scl_d = 1'b0;
          end
        end
        i2cw_pkg::ACT_STOP: begin
          if (step_d == StepW'(1)) begin
            scl_d = 1'b0;
          end else if (step_d == StepW'(2)) begin
            sda_d = 1'b0;
          end else if (step_d == StepW'(3)) begin
            scl_d = 1'b1;
          end else begin
            sda_d = 1'b1;
          end
        end
        default: begin
          if (step_d <= i2cw_pkg::DataPhasesEnd) begin
            // each data bit: drive SDA, raise SCL, lower SCL and shift
            case (sub_d)
              2'd0:    sda_d = shift_d[ByteW-1];
              2'd1:    scl_d = 1'b1;
              default: begin
                scl_d   = 1'b0;
                shift_d = {shift_d[ByteW-2:0], 1'b0};
              end
            endcase
          end else if (step_d == i2cw_pkg::SdaReleasePh) begin
            sda_d = 1'b1;
          end else if (step_d == i2cw_pkg::AckSamplePhase) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2cw_pkg::PhaseTicksRst;
      step_q        <= '0;
      kind_q        <= i2cw_pkg::ACT_TICK;
      wait_q        <= '0;
      shift_q       <= '0;
      sub_q         <= '0;
      scl_q         <= 1'b1;
      sda_q         <= 1'b1;
      ack_q         <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        phase_ticks_q <= cfg_i.data;
      end
      if (fire_i) begin
        step_q  <= step_d;
        kind_q  <= kind_d;
        wait_q  <= wait_d;
        shift_q <= shift_d;
        sub_q   <= sub_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        ack_q   <= ack_d;
      end
    end
  end

  assign result_o.scl_level = scl_d;
  assign result_o.sda_level = sda_d;
  assign result_o.busy_res  = (step_d != '0);
  assign result_o.done_res  = done;
  assign result_o.acked     = acked;
  assign result_o.rejected  = rejected;

endmodule

/* rtl/i2cw_out_reg.sv */
// Result register: holds one result word until the sink takes it.
// Depends on i2cw_pkg and i2cw_chan_if.
module i2cw_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  i2cw_pkg::out_item_t result_i,
  output logic                space_o,
  i2cw_chan_if.source         out_o
);

  logic                valid_q;
  i2cw_pkg::out_item_t result_q;

  assign space_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = result_q;

endmodule

/* rtl/i2c_master_write_engine_core.sv */
// Top level of the write-only I2C master engine.
// Depends on i2cw_pkg, i2cw_chan_if, i2cw_in_reg, i2cw_seq and i2cw_out_reg.
//
//   port    dir   word                        handshake
//   in_i    in    action, byte_value, sda_in  valid/ready
//   out_o   out   pin levels and status       valid/ready
//   cfg_i   in    phase_ticks (8 bits)        valid/ready, always ready
//
// One word per clock when the sink keeps up. A word accepted at in_i is
// held in the input register; the sequencer processes it, and its result
// enters the result register once that register has space. The out_o
// handshake trails the in_i one by the input and the result register.
// The sequencer state advances once per word, so the hold counter
// counts words, not clocks. A stalled sink holds the result register and
// backs up through the input register. Reset leaves the pins released,
// the sequencer idle and phase_ticks at 20.
module i2c_master_write_engine_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  i2cw_chan_if.sink   in_i,
  i2cw_chan_if.sink   cfg_i,
  i2cw_chan_if.source out_o
);

  logic                s1_valid;
  i2cw_pkg::in_item_t  s1_item;
  logic                space;
  logic                fire;
  i2cw_pkg::out_item_t result;

  assign fire = s1_valid && space;

  i2cw_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (fire),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  i2cw_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .fire_i   (fire),
    .item_i   (s1_item),
    .result_o (result)
  );

  i2cw_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .result_i (result),
    .space_o  (space),
    .out_o    (out_o)
  );

endmodule

/* tb/tb.sv */
// Self-checking bench for i2c_master_write_engine_core: drives command words,
// predicts pin levels and status per word, and checks every result word.
// Depends on i2cw_pkg and i2cw_chan_if from the RTL.
module tb;

  localparam int unsigned StepW = i2cw_pkg::StepW;
  localparam int unsigned TickW = i2cw_pkg::TickW;
  localparam int unsigned ByteW = i2cw_pkg::ByteW;

  logic clk_i = 1'b0;
  logic rst_ni;

  i2cw_chan_if #(.payload_t(i2cw_pkg::in_item_t))  in_if  ();
  i2cw_chan_if #(.payload_t(i2cw_pkg::cfg_word_t)) cfg_if ();
  i2cw_chan_if #(.payload_t(i2cw_pkg::out_item_t)) out_if ();

  i2c_master_write_engine_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // engine state as the bench sees it
  i2cw_pkg::cfg_word_t tick_setting;
  logic [StepW-1:0]    eng_step;
  i2cw_pkg::action_e   eng_kind;
  logic [TickW-1:0]    eng_wait;
  logic [ByteW-1:0]    eng_shift;
  logic                eng_scl;
  logic                eng_sda;
  logic                eng_ack;

  i2cw_pkg::out_item_t status_due[$];
  int unsigned fail_count = 0;
  bit          src_gaps   = 1'b1;
  bit          sink_gaps  = 1'b1;
  bit          hold_req   = 1'b0;

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
  endfunction

  function automatic logic [TickW-1:0] hold_len();
    return (tick_setting == '0) ? TickW'(1) : tick_setting;
  endfunction

  // pin change made on entering phase step of the current command
  function automatic void take_phase(logic [StepW-1:0] step);
    int sub;
    sub = (int'(step) - 1) % 3;
    if (eng_kind == i2cw_pkg::ACT_START) begin
      if (step == StepW'(1)) begin
        eng_sda = 1'b1;
        eng_scl = 1'b1;
      end else if (step == StepW'(2)) eng_sda = 1'b0;
      else eng_scl = 1'b0;
    end else if (eng_kind == i2cw_pkg::ACT_STOP) begin
      if (step == StepW'(1)) eng_scl = 1'b0;
      else if (step == StepW'(2)) eng_sda = 1'b0;
      else if (step == StepW'(3)) eng_scl = 1'b1;
      else eng_sda = 1'b1;
    end else if (step <= i2cw_pkg::DataPhasesEnd) begin
      if (sub == 0) eng_sda = eng_shift[ByteW-1];
      else if (sub == 1) eng_scl = 1'b1;
      else begin
        eng_scl   = 1'b0;
        eng_shift = eng_shift << 1;
      end
    end else if (step == i2cw_pkg::SdaReleasePh) eng_sda = 1'b1;
    else if (step == i2cw_pkg::AckSamplePhase) eng_scl = 1'b1;
    else eng_scl = 1'b0;
  endfunction

  function automatic void advance_engine(i2cw_pkg::in_item_t w);
    i2cw_pkg::out_item_t r;
    logic [StepW-1:0]    last;
    logic                fin;
    logic                rej;
    logic                ack;
    fin = 1'b0;
    rej = 1'b0;
    ack = 1'b0;
    case (eng_kind)
      i2cw_pkg::ACT_START: last = i2cw_pkg::StartPhases;
      i2cw_pkg::ACT_STOP:  last = i2cw_pkg::StopPhases;
      default:             last = i2cw_pkg::WritePhases;
    endcase
    if (eng_step != '0) begin
      // a command while busy only counts as a tick
      if (w.action != i2cw_pkg::ACT_TICK) rej = 1'b1;
      if (eng_wait > TickW'(1)) eng_wait = eng_wait - TickW'(1);
      else begin
        eng_wait = '0;
        if (eng_kind == i2cw_pkg::ACT_WRITE && eng_step == i2cw_pkg::AckSamplePhase)
          eng_ack = ~w.sda_in;
        if (eng_step >= last) begin
          fin = 1'b1;
          if (eng_kind == i2cw_pkg::ACT_WRITE) ack = eng_ack;
          eng_step = '0;
        end else begin
          eng_step = eng_step + StepW'(1);
          take_phase(eng_step);
          eng_wait = hold_len();
        end
      end
    end else if (w.action != i2cw_pkg::ACT_TICK) begin
      eng_kind = w.action;
      eng_ack  = 1'b0;
      if (w.action == i2cw_pkg::ACT_WRITE) eng_shift = w.byte_value;
      eng_step = StepW'(1);
      take_phase(StepW'(1));
      eng_wait = hold_len();
    end
    r.scl_level = eng_scl;
    r.sda_level = eng_sda;
    r.busy_res  = (eng_step != '0);
    r.done_res  = fin;
    r.acked     = ack;
    r.rejected  = rej;
    status_due.push_back(r);
  endfunction

  function automatic void compare_bit(string field, logic want, logic got);
    if (want !== got) begin
      $display("%0t: mismatch on %s, expected %0b, actual %0b", $time, field, want, got);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    i2cw_pkg::out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (status_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %b", $time, out_if.data);
        fail_count++;
      end else begin
        want = status_due.pop_front();
        compare_bit("scl_level", want.scl_level, out_if.data.scl_level);
        compare_bit("sda_level", want.sda_level, out_if.data.sda_level);
        compare_bit("busy_res",  want.busy_res,  out_if.data.busy_res);
        compare_bit("done_res",  want.done_res,  out_if.data.done_res);
        compare_bit("acked",     want.acked,     out_if.data.acked);
        compare_bit("rejected",  want.rejected,  out_if.data.rejected);
      end
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    int unsigned n;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        for (n = 0; n < 60; n++) @(posedge clk_i);
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  task automatic push_word(i2cw_pkg::action_e act, logic [ByteW-1:0] val, logic sda);
    i2cw_pkg::in_item_t w;
    w.action     = act;
    w.byte_value = val;
    w.sda_in     = sda;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    advance_engine(w);
  endtask

  task automatic tick_until_idle(logic sda);
    while (eng_step != '0) push_word(i2cw_pkg::ACT_TICK, '0, sda);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_ticks(i2cw_pkg::cfg_word_t val);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    tick_setting = val;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // reset hold time, idle ticks on both line levels
  task automatic test_reset_ticks();
    push_word(i2cw_pkg::ACT_TICK, 8'h00, 1'b0);
    push_word(i2cw_pkg::ACT_TICK, 8'hFF, 1'b1);
    push_word(i2cw_pkg::ACT_START, 8'h00, 1'b1);
    tick_until_idle(1'b1);
  endtask

  // zero hold is taken as one tick
  task automatic test_zero_ticks();
    write_ticks('0);
    push_word(i2cw_pkg::ACT_WRITE, 8'hFF, 1'b0);
    tick_until_idle(1'b0);
  endtask

  task automatic test_commands();
    write_ticks(TickW'(1));
    push_word(i2cw_pkg::ACT_START, 8'h00, 1'b1);
    tick_until_idle(1'b1);
    push_word(i2cw_pkg::ACT_WRITE, 8'hA5, 1'b0);
    push_word(i2cw_pkg::ACT_START, 8'h00, 1'b0);
    push_word(i2cw_pkg::ACT_STOP, 8'h00, 1'b0);
    push_word(i2cw_pkg::ACT_WRITE, 8'h5A, 1'b0);
    tick_until_idle(1'b0);
    // no ack: line stays high
    push_word(i2cw_pkg::ACT_WRITE, 8'h00, 1'b1);
    tick_until_idle(1'b1);
    push_word(i2cw_pkg::ACT_STOP, 8'h00, 1'b1);
    tick_until_idle(1'b1);
  endtask

  task automatic test_long_hold();
    write_ticks(TickW'(24));
    push_word(i2cw_pkg::ACT_START, 8'h00, 1'b1);
    tick_until_idle(1'b1);
  endtask

  task automatic test_backpressure();
    int unsigned n;
    write_ticks(TickW'(1));
    src_gaps = 1'b0;
    hold_req = 1'b1;
    push_word(i2cw_pkg::ACT_WRITE, 8'($urandom), 1'b0);
    for (n = 0; n < 40; n++) push_word(i2cw_pkg::ACT_TICK, '0, 1'($urandom_range(0, 1)));
    tick_until_idle(1'b0);
    src_gaps = 1'b1;
  endtask

  task automatic test_random_traffic(i2cw_pkg::cfg_word_t ticks, int unsigned count,
                                     bit gaps);
    i2cw_pkg::action_e act;
    int unsigned       taken;
    write_ticks(ticks);
    src_gaps  = gaps;
    sink_gaps = gaps;
    taken     = 0;
    while (taken < count) begin
      // mostly whole commands, with some commands thrown in while busy
      if (eng_step == '0)
        act = ($urandom_range(0, 4) == 0) ? i2cw_pkg::ACT_TICK
                                          : i2cw_pkg::action_e'($urandom_range(1, 3));
      else
        act = ($urandom_range(0, 11) == 0) ? i2cw_pkg::action_e'($urandom_range(1, 3))
                                           : i2cw_pkg::ACT_TICK;
      if (eng_step != '0 || act != i2cw_pkg::ACT_TICK) taken++;
      push_word(act, 8'($urandom), 1'($urandom_range(0, 1)));
    end
    tick_until_idle(1'($urandom_range(0, 1)));
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  initial begin
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    tick_setting = i2cw_pkg::PhaseTicksRst;
    eng_step     = '0;
    eng_kind     = i2cw_pkg::ACT_TICK;
    eng_wait     = '0;
    eng_shift    = '0;
    eng_scl      = 1'b1;
    eng_sda      = 1'b1;
    eng_ack      = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_ticks();
    test_zero_ticks();
    test_commands();
    test_long_hold();
    test_backpressure();
    test_random_traffic(TickW'(1), 25, 1'b1);
    test_random_traffic(TickW'(2), 25, 1'b0);
    test_random_traffic(TickW'(3), 20, 1'b1);
    test_random_traffic(TickW'($urandom_range(1, 6)), 20, 1'b1);

    drain();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
